// File: rtl/core/qrs_pkg.sv
package qrs_pkg;

  localparam int CoefW = 24;
  localparam int ThrW = 23;
  localparam int DiscW = 50;
  localparam int RadW = 64;
  localparam int RootW = 32;
  localparam int NumW = 42;
  localparam int UdW = CoefW;
  localparam int SqrtStages = RootW / 2;
  localparam int DivStages = RootW / 2;

  localparam logic [2:0] CASE_IDENTITY = 3'd0;
  localparam logic [2:0] CASE_CONTRA = 3'd1;
  localparam logic [2:0] CASE_LINEAR = 3'd2;
  localparam logic [2:0] CASE_TWO_REAL = 3'd3;
  localparam logic [2:0] CASE_REPEATED = 3'd4;
  localparam logic [2:0] CASE_COMPLEX = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic signed [DiscW-1:0] disc;
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] c;
  } sqr_side_t;

  typedef struct packed {
    logic [2:0] kind;
    logic signed [DiscW-1:0] disc;
  } div_side_t;

  typedef struct packed {
    logic [RootW-1:0] q;
    logic big;
    logic neg;
  } quo_t;

  typedef struct packed {
    logic [RootW-1:0] val;
    logic sat;
  } root_t;

  function automatic root_t fmt_root(quo_t x);
    root_t r;
    r.sat = 1'b0;
    r.val = x.q;
    if (x.neg) begin
      if (x.big || (x.q > {1'b1, {(RootW-1){1'b0}}})) begin
        r.sat = 1'b1;
        r.val = {1'b1, {(RootW-1){1'b0}}};
      end else begin
        r.val = ~x.q + {{(RootW-1){1'b0}}, 1'b1};
      end
    end else if (x.big || x.q[RootW-1]) begin
      r.sat = 1'b1;
      r.val = {1'b0, {(RootW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/qrs_front.sv
module qrs_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_v,
  input  logic signed [qrs_pkg::CoefW-1:0] in_a,
  input  logic signed [qrs_pkg::CoefW-1:0] in_b,
  input  logic signed [qrs_pkg::CoefW-1:0] in_c,
  input  logic        [qrs_pkg::ThrW-1:0]  thr,
  input  logic                             down_rdy,
  output logic                             up_rdy,
  output logic                             out_v,
  output qrs_pkg::sqr_side_t               out_side,
  output logic        [qrs_pkg::RadW-1:0]  out_rad
);

  logic va_r, vb_r, en_a, en_b;
  logic signed [qrs_pkg::CoefW-1:0] a_r, b_r, c_r;
  logic signed [2*qrs_pkg::CoefW-1:0] bb_r, ac_r, bb_nxt, ac_nxt;
  logic za_r, zb_r, zc_r;
  qrs_pkg::sqr_side_t side_r, side_nxt;
  logic [qrs_pkg::RadW-1:0] rad_r, rad_nxt;
  logic signed [qrs_pkg::DiscW:0] d_full, t_full;
  logic [qrs_pkg::DiscW-1:0] d_mag, t_mag;

  function automatic logic is_zero(logic signed [qrs_pkg::CoefW-1:0] x,
                                   logic [qrs_pkg::ThrW-1:0] t);
    logic [qrs_pkg::CoefW-1:0] m;
    m = x[qrs_pkg::CoefW-1] ? (~x + 1'b1) : x;
    return (x == '0) || (m < {1'b0, t});
  endfunction

  assign en_b = !vb_r || down_rdy;
  assign en_a = !va_r || en_b;
  assign up_rdy = en_a;

  assign bb_nxt = in_b * in_b;
  assign ac_nxt = in_a * in_c;

  always_comb begin
    d_full = (qrs_pkg::DiscW+1)'(bb_r) - ((qrs_pkg::DiscW+1)'(ac_r) <<< 2);
    t_full = {12'd0, thr, 16'd0};
    t_mag = {11'd0, thr, 16'd0};
    d_mag = d_full[qrs_pkg::DiscW-1] ? (~d_full[qrs_pkg::DiscW-1:0] + 1'b1)
                                     : d_full[qrs_pkg::DiscW-1:0];
    rad_nxt = {d_mag, 14'd0};
    side_nxt.disc = d_full[qrs_pkg::DiscW-1:0];
    side_nxt.a = a_r;
    side_nxt.b = b_r;
    side_nxt.c = c_r;
    if (za_r) begin
      if (zb_r) begin
        side_nxt.kind = zc_r ? qrs_pkg::CASE_IDENTITY : qrs_pkg::CASE_CONTRA;
      end else begin
        side_nxt.kind = qrs_pkg::CASE_LINEAR;
      end
    end else if (d_full > t_full) begin
      side_nxt.kind = qrs_pkg::CASE_TWO_REAL;
    end else if (d_full[qrs_pkg::DiscW] && (d_mag >= t_mag)) begin
      side_nxt.kind = qrs_pkg::CASE_COMPLEX;
    end else begin
      side_nxt.kind = qrs_pkg::CASE_REPEATED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_v;
      if (en_b) vb_r <= va_r;
    end
    if (en_a) begin
      a_r <= in_a;
      b_r <= in_b;
      c_r <= in_c;
      bb_r <= bb_nxt;
      ac_r <= ac_nxt;
      za_r <= is_zero(in_a, thr);
      zb_r <= is_zero(in_b, thr);
      zc_r <= is_zero(in_c, thr);
    end
    if (en_b) begin
      side_r <= side_nxt;
      rad_r <= rad_nxt;
    end
  end

  assign out_v = vb_r;
  assign out_side = side_r;
  assign out_rad = rad_r;

endmodule

// File: rtl/core/qrs_sqrt.sv
module qrs_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_v,
  input  qrs_pkg::sqr_side_t               in_side,
  input  logic        [qrs_pkg::RadW-1:0]  in_rad,
  input  logic                             down_rdy,
  output logic                             up_rdy,
  output logic                             out_v,
  output qrs_pkg::sqr_side_t               out_side,
  output logic        [qrs_pkg::RootW-1:0] out_root
);

  localparam int N = qrs_pkg::SqrtStages;
  localparam int W = qrs_pkg::RadW;

  logic vld_r [N];
  logic en [N];
  logic [W-1:0] v_r [N];
  logic [W-1:0] r_r [N];
  qrs_pkg::sqr_side_t side_r [N];

  function automatic logic [2*W-1:0] step2(logic [W-1:0] v, logic [W-1:0] r, int k);
    logic [W-1:0] vv, rr, bt;
    vv = v;
    rr = r;
    for (int i = 0; i < 2; i++) begin
      bt = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 4 * k - 2 * i);
      if (vv >= rr + bt) begin
        vv = vv - (rr + bt);
        rr = (rr >> 1) + bt;
      end else begin
        rr = rr >> 1;
      end
    end
    return {vv, rr};
  endfunction

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W-1:0] v_in, r_in;
    logic vld_in;
    qrs_pkg::sqr_side_t side_in;
    logic [2*W-1:0] step_nxt;

    if (k == 0) begin : g_first
      assign v_in = in_rad;
      assign r_in = '0;
      assign vld_in = in_v;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in = v_r[k-1];
      assign r_in = r_r[k-1];
      assign vld_in = vld_r[k-1];
      assign side_in = side_r[k-1];
    end

    if (k == N - 1) begin : g_last
      assign en[k] = !vld_r[k] || down_rdy;
    end else begin : g_mid
      assign en[k] = !vld_r[k] || en[k+1];
    end

    assign step_nxt = step2(v_in, r_in, k);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en[k]) begin
        vld_r[k] <= vld_in;
      end
      if (en[k]) begin
        v_r[k] <= step_nxt[2*W-1:W];
        r_r[k] <= step_nxt[W-1:0];
        side_r[k] <= side_in;
      end
    end
  end

  assign up_rdy = en[0];
  assign out_v = vld_r[N-1];
  assign out_side = side_r[N-1];
  assign out_root = r_r[N-1][qrs_pkg::RootW-1:0];

endmodule

// File: rtl/core/qrs_div.sv
module qrs_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_v,
  input  qrs_pkg::sqr_side_t               in_side,
  input  logic        [qrs_pkg::RootW-1:0] in_root,
  input  logic                             down_rdy,
  output logic                             up_rdy,
  output logic                             out_v,
  output qrs_pkg::div_side_t               out_side,
  output qrs_pkg::quo_t                    out_q0,
  output qrs_pkg::quo_t                    out_q1
);

  localparam int N = qrs_pkg::DivStages;
  localparam int NW = qrs_pkg::NumW;
  localparam int UW = qrs_pkg::UdW;
  localparam int QW = qrs_pkg::RootW;
  localparam int CW = UW + QW;

  logic vn_r, vp_r, vb_r, en_n, en_p, en_b;
  logic en_s [N];
  logic vld_r [N];

  logic signed [NW-1:0] n_nxt [2];
  logic signed [NW-1:0] n_r [2];
  logic neg_nxt [2];
  logic neg_n_r [2];
  logic neg_p_r [2];
  logic neg_b_r [2];
  logic signed [UW-1:0] dd;
  logic [UW-1:0] ud_nxt, ud_n_r, ud_p_r, ud_b_r;
  logic [NW-1:0] un_nxt [2];
  logic [NW-1:0] un_p_r [2];
  logic [NW-1:0] rem_b_r [2];
  logic big_b_r [2];
  qrs_pkg::div_side_t side_nxt, side_n_r, side_p_r, side_b_r;
  logic signed [NW-1:0] nb, s8, nc;
  logic [NW-1:0] half;

  logic [NW-1:0] rem_r [N][2];
  logic [QW-1:0] q_r [N][2];
  logic big_r [N][2];
  logic neg_r [N][2];
  logic [UW-1:0] ud_r [N];
  qrs_pkg::div_side_t side_r [N];

  function automatic logic [NW+QW-1:0] div_step(logic [NW-1:0] rem, logic [QW-1:0] q,
                                                logic [UW-1:0] ud, int j);
    logic [CW-1:0] rr, dsh;
    logic [NW-1:0] rm;
    logic [QW-1:0] qq;
    rm = rem;
    qq = q;
    for (int i = 0; i < 2; i++) begin
      dsh = {{QW{1'b0}}, ud} << (QW - 1 - 2 * j - i);
      rr = {{(CW-NW){1'b0}}, rm};
      if (rr >= dsh) begin
        rr = rr - dsh;
        rm = rr[NW-1:0];
        qq[QW - 1 - 2 * j - i] = 1'b1;
      end
    end
    return {rm, qq};
  endfunction

  assign en_b = !vb_r || en_s[0];
  assign en_p = !vp_r || en_b;
  assign en_n = !vn_r || en_p;
  assign up_rdy = en_n;

  always_comb begin
    nb = -(NW'(in_side.b) <<< 15);
    nc = -(NW'(in_side.c) <<< 16);
    s8 = signed'({2'b00, in_root, 8'd0});
    side_nxt.kind = in_side.kind;
    side_nxt.disc = in_side.disc;
    dd = in_side.a;
    n_nxt[0] = '0;
    n_nxt[1] = '0;
    case (in_side.kind)
      qrs_pkg::CASE_LINEAR: begin
        dd = in_side.b;
        n_nxt[0] = nc;
      end
      qrs_pkg::CASE_TWO_REAL: begin
        n_nxt[0] = nb + s8;
        n_nxt[1] = nb - s8;
      end
      qrs_pkg::CASE_REPEATED: begin
        n_nxt[0] = nb;
      end
      qrs_pkg::CASE_COMPLEX: begin
        n_nxt[0] = nb;
        n_nxt[1] = s8;
      end
      default: begin
        n_nxt[0] = '0;
      end
    endcase
    ud_nxt = dd[UW-1] ? (~dd + 1'b1) : dd;
    neg_nxt[0] = n_nxt[0][NW-1] ^ dd[UW-1];
    neg_nxt[1] = n_nxt[1][NW-1] ^ dd[UW-1];
  end

  always_comb begin
    half = {{(NW-UW+1){1'b0}}, ud_n_r[UW-1:1]};
    for (int i = 0; i < 2; i++) begin
      un_nxt[i] = n_r[i][NW-1] ? (half - NW'(n_r[i])) : (NW'(n_r[i]) + half);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn_r <= 1'b0;
      vp_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_n) vn_r <= in_v;
      if (en_p) vp_r <= vn_r;
      if (en_b) vb_r <= vp_r;
    end
    if (en_n) begin
      n_r[0] <= n_nxt[0];
      n_r[1] <= n_nxt[1];
      neg_n_r[0] <= neg_nxt[0];
      neg_n_r[1] <= neg_nxt[1];
      ud_n_r <= ud_nxt;
      side_n_r <= side_nxt;
    end
    if (en_p) begin
      un_p_r[0] <= un_nxt[0];
      un_p_r[1] <= un_nxt[1];
      neg_p_r[0] <= neg_n_r[0];
      neg_p_r[1] <= neg_n_r[1];
      ud_p_r <= ud_n_r;
      side_p_r <= side_n_r;
    end
    if (en_b) begin
      for (int i = 0; i < 2; i++) begin
        rem_b_r[i] <= un_p_r[i];
        big_b_r[i] <= {{(CW-NW){1'b0}}, un_p_r[i]} >= {ud_p_r, {QW{1'b0}}};
        neg_b_r[i] <= neg_p_r[i];
      end
      ud_b_r <= ud_p_r;
      side_b_r <= side_p_r;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [NW-1:0] rem_in [2];
    logic [QW-1:0] q_in [2];
    logic big_in [2];
    logic neg_in [2];
    logic [UW-1:0] ud_in;
    logic vld_in;
    qrs_pkg::div_side_t side_in;
    logic [NW+QW-1:0] step_nxt [2];

    if (k == 0) begin : g_first
      assign vld_in = vb_r;
      assign ud_in = ud_b_r;
      assign side_in = side_b_r;
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign rem_in[l] = rem_b_r[l];
        assign q_in[l] = '0;
        assign big_in[l] = big_b_r[l];
        assign neg_in[l] = neg_b_r[l];
      end
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign ud_in = ud_r[k-1];
      assign side_in = side_r[k-1];
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign rem_in[l] = rem_r[k-1][l];
        assign q_in[l] = q_r[k-1][l];
        assign big_in[l] = big_r[k-1][l];
        assign neg_in[l] = neg_r[k-1][l];
      end
    end

    if (k == N - 1) begin : g_last
      assign en_s[k] = !vld_r[k] || down_rdy;
    end else begin : g_mid
      assign en_s[k] = !vld_r[k] || en_s[k+1];
    end

    assign step_nxt[0] = div_step(rem_in[0], q_in[0], ud_in, k);
    assign step_nxt[1] = div_step(rem_in[1], q_in[1], ud_in, k);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en_s[k]) begin
        vld_r[k] <= vld_in;
      end
      if (en_s[k]) begin
        for (int l = 0; l < 2; l++) begin
          rem_r[k][l] <= step_nxt[l][NW+QW-1:QW];
          q_r[k][l] <= step_nxt[l][QW-1:0];
          big_r[k][l] <= big_in[l];
          neg_r[k][l] <= neg_in[l];
        end
        ud_r[k] <= ud_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_v = vld_r[N-1];
  assign out_side = side_r[N-1];
  assign out_q0 = {q_r[N-1][0], big_r[N-1][0], neg_r[N-1][0]};
  assign out_q1 = {q_r[N-1][1], big_r[N-1][1], neg_r[N-1][1]};

endmodule

// File: rtl/core/quadratic_root_solver_core.sv
// Quadratic equation solver for signed Q8.16 coefficients a, b and c.
// A request enters on in_valid with in_stall low and carries the three
// coefficients. Each request gives exactly one result on the out_ channel,
// holding the case code, the root count, two Q16.16 complex roots, the
// Q18.32 discriminant with its valid flag and a saturation flag.
// The zero threshold is written through cfg_wr_en and cfg_wr_data; it must
// only change while no request is in flight, and it resets to one.
// From acceptance to out_valid a request passes the product and discriminant
// registers, the square root at two result bits per stage, the numerator
// registers and the two-lane divider at two quotient bits per stage, and one
// output register. Throughput is one request per cycle while out_stall is low.
// Every stage holds a valid bit, so a stalled receiver freezes only the full
// stages behind the output, and empty stages keep filling until the pipeline
// is full; in_stall then rises.
// Synchronous reset empties the pipeline and clears out_valid.
module quadratic_root_solver_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic        [qrs_pkg::ThrW-1:0]   cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [qrs_pkg::CoefW-1:0]  in_coef_square,
  input  logic signed [qrs_pkg::CoefW-1:0]  in_coef_linear,
  input  logic signed [qrs_pkg::CoefW-1:0]  in_coef_const,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [2:0]                 out_solution_case,
  output logic        [1:0]                 out_root_count,
  output logic signed [qrs_pkg::RootW-1:0]  out_first_root_real,
  output logic signed [qrs_pkg::RootW-1:0]  out_first_root_imag,
  output logic signed [qrs_pkg::RootW-1:0]  out_second_root_real,
  output logic signed [qrs_pkg::RootW-1:0]  out_second_root_imag,
  output logic signed [qrs_pkg::DiscW-1:0]  out_disc_value,
  output logic                              out_disc_valid,
  output logic                              out_root_saturated
);

  logic [qrs_pkg::ThrW-1:0] thr_r;
  logic front_rdy, front_v, sqrt_rdy, sqrt_v, div_rdy, div_v, en_o;
  qrs_pkg::sqr_side_t front_side, sqrt_side;
  logic [qrs_pkg::RadW-1:0] front_rad;
  logic [qrs_pkg::RootW-1:0] sqrt_root;
  qrs_pkg::div_side_t div_side;
  qrs_pkg::quo_t q0, q1, q1_flip;
  qrs_pkg::root_t rt0, rt1, rt1_flip;

  logic out_valid_r;
  logic [2:0] case_r, case_nxt;
  logic [1:0] count_r, count_nxt;
  logic [qrs_pkg::RootW-1:0] r1_r, i1_r, r2_r, i2_r, r1_nxt, i1_nxt, r2_nxt, i2_nxt;
  logic [qrs_pkg::DiscW-1:0] disc_r, disc_nxt;
  logic dvalid_r, dvalid_nxt, sat_r, sat_nxt;

  qrs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (in_valid),
    .in_a     (in_coef_square),
    .in_b     (in_coef_linear),
    .in_c     (in_coef_const),
    .thr      (thr_r),
    .down_rdy (sqrt_rdy),
    .up_rdy   (front_rdy),
    .out_v    (front_v),
    .out_side (front_side),
    .out_rad  (front_rad)
  );

  qrs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (front_v),
    .in_side  (front_side),
    .in_rad   (front_rad),
    .down_rdy (div_rdy),
    .up_rdy   (sqrt_rdy),
    .out_v    (sqrt_v),
    .out_side (sqrt_side),
    .out_root (sqrt_root)
  );

  qrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (sqrt_v),
    .in_side  (sqrt_side),
    .in_root  (sqrt_root),
    .down_rdy (en_o),
    .up_rdy   (div_rdy),
    .out_v    (div_v),
    .out_side (div_side),
    .out_q0   (q0),
    .out_q1   (q1)
  );

  assign in_stall = !front_rdy;
  assign en_o = !out_valid_r || !out_stall;

  always_comb begin
    q1_flip = q1;
    q1_flip.neg = !q1.neg;
    rt0 = qrs_pkg::fmt_root(q0);
    rt1 = qrs_pkg::fmt_root(q1);
    rt1_flip = qrs_pkg::fmt_root(q1_flip);
    case_nxt = div_side.kind;
    count_nxt = 2'd0;
    r1_nxt = '0;
    i1_nxt = '0;
    r2_nxt = '0;
    i2_nxt = '0;
    disc_nxt = '0;
    dvalid_nxt = 1'b0;
    sat_nxt = 1'b0;
    case (div_side.kind)
      qrs_pkg::CASE_LINEAR: begin
        count_nxt = 2'd1;
        r1_nxt = rt0.val;
        sat_nxt = rt0.sat;
      end
      qrs_pkg::CASE_TWO_REAL: begin
        count_nxt = 2'd2;
        r1_nxt = rt0.val;
        r2_nxt = rt1.val;
        disc_nxt = div_side.disc;
        dvalid_nxt = 1'b1;
        sat_nxt = rt0.sat || rt1.sat;
      end
      qrs_pkg::CASE_REPEATED: begin
        count_nxt = 2'd1;
        r1_nxt = rt0.val;
        disc_nxt = div_side.disc;
        dvalid_nxt = 1'b1;
        sat_nxt = rt0.sat;
      end
      qrs_pkg::CASE_COMPLEX: begin
        count_nxt = 2'd2;
        r1_nxt = rt0.val;
        r2_nxt = rt0.val;
        i1_nxt = rt1.val;
        i2_nxt = rt1_flip.val;
        disc_nxt = div_side.disc;
        dvalid_nxt = 1'b1;
        sat_nxt = rt0.sat || rt1.sat || rt1_flip.sat;
      end
      default: begin
        count_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= {{(qrs_pkg::ThrW-1){1'b0}}, 1'b1};
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (en_o) out_valid_r <= div_v;
    end
    if (en_o) begin
      case_r <= case_nxt;
      count_r <= count_nxt;
      r1_r <= r1_nxt;
      i1_r <= i1_nxt;
      r2_r <= r2_nxt;
      i2_r <= i2_nxt;
      disc_r <= disc_nxt;
      dvalid_r <= dvalid_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_solution_case = case_r;
  assign out_root_count = count_r;
  assign out_first_root_real = r1_r;
  assign out_first_root_imag = i1_r;
  assign out_second_root_real = r2_r;
  assign out_second_root_imag = i2_r;
  assign out_disc_value = disc_r;
  assign out_disc_valid = dvalid_r;
  assign out_root_saturated = sat_r;

endmodule
